FILE: rtl/plist_pkg.sv
// Shared types and codes for the positional list engine.
package plist_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_MID   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_MID   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd5;
    localparam logic [OP_W-1:0] OP_DEL_INDEX = 3'd6;
    // Spare code: leaves the list alone and reports OK.
    localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } plist_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;
        logic signed [WORD_W-1:0] removed_value;
    } plist_rsp_t;

endpackage

FILE: rtl/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer plus list storage RAM.
//
// A request is taken at a rising clock edge where start is high and busy is
// low. It carries an operation code, a word to insert and an index for the
// delete-at-index operation. Each request produces exactly one result: done
// is high for one cycle while result holds the status, the new length and
// the removed word. The receiver cannot hold a result off.
//
// The list lives in one RAM with a registered read port, read and written
// one entry per cycle. With k = n - position, an insert moves k entries up
// and a delete reads k entries, keeps the first and moves the rest down.
// An insert at the tail (k = 0) moves nothing and only writes the new word;
// rejected requests (full, empty, out of range) and the unused code leave
// the RAM alone. busy is low whenever done is high, so the next request can
// be taken at the edge that takes the result.
//
// Reset empties the list at once; no clearing pass runs, since entries
// outside the current length are never read.
module positional_list_engine_core #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  plist_pkg::plist_req_t request,
    output logic                  busy,
    output logic                  done,
    output plist_pkg::plist_rsp_t result
);

    import plist_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // RAM port signals between the sequencer and the list storage.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // The sequencer decodes each request, checks it against the current
    // length and runs the shift through the RAM.
    plist_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // List storage, one word per position.
    plist_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/plist_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/plist_ctrl.sv
// Sequencer that decodes list requests and shifts entries through the RAM.
module plist_ctrl #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  plist_pkg::plist_req_t        request,
    output logic                         busy,
    output logic                         done,
    output plist_pkg::plist_rsp_t        result,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [plist_pkg::WORD_W-1:0] ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [plist_pkg::WORD_W-1:0] ram_rdata
);

    import plist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_DEL  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [AW-1:0]       at_reg, at_next;
    logic [AW-1:0]       last_reg, last_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic [WORD_W-1:0]   removed_reg, removed_next;
    plist_rsp_t          rsp_reg, rsp_next;

    logic [CW-1:0]       ins_at;
    logic [31:0]         del_at;
    logic                is_insert;

    // Target position for each kind of operation, from the current count or, for delete at index, the request.
    always_comb
    begin
        ins_at    = '0;
        del_at    = '0;
        is_insert = 1'b0;
        unique case (request.operation)
            OP_INS_HEAD:
            begin
                ins_at    = '0;
                is_insert = 1'b1;
            end
            OP_INS_MID:
            begin
                ins_at    = (count_reg == CW'(1)) ? count_reg : (count_reg >> 1);
                is_insert = 1'b1;
            end
            OP_INS_TAIL:
            begin
                ins_at    = count_reg;
                is_insert = 1'b1;
            end
            OP_DEL_HEAD:  del_at = '0;
            OP_DEL_MID:   del_at = (count_reg <= CW'(1)) ? '0 : 32'(count_reg >> 1);
            OP_DEL_TAIL:  del_at = 32'(count_reg) - 32'd1;
            OP_DEL_INDEX: del_at = 32'(request.position);
            default:      del_at = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        done_next      = 1'b0;
        rd_addr_next   = rd_addr_reg;
        at_next        = at_reg;
        last_next      = last_reg;
        pend_addr_next = rd_addr_reg;
        value_next     = value_reg;
        removed_next   = removed_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next            = request.value;
                    rsp_next.status       = ST_OK;
                    rsp_next.length       = LEN_W'(count_reg);
                    rsp_next.removed_value = '0;
                    if (request.operation == OP_UNUSED)
                    begin
                        // Unused code: report success without touching the list.
                        done_next = 1'b1;
                    end
                    else if (is_insert)
                    begin
                        if (count_reg >= CW'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            at_next      = AW'(ins_at);
                            rd_addr_next = AW'(count_reg - CW'(1));
                            issue_next   = (ins_at != count_reg);
                            state_next   = S_INS;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                        done_next       = 1'b1;
                    end
                    else if (del_at >= 32'(count_reg))
                    begin
                        rsp_next.status = ST_RANGE;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        at_next      = AW'(del_at);
                        rd_addr_next = AW'(del_at);
                        last_next    = AW'(count_reg - CW'(1));
                        issue_next   = 1'b1;
                        state_next   = S_DEL;
                    end
                end
            end

            S_INS:
            begin
                // Read downward from the tail; each word lands one place higher.
                ram_re         = issue_reg;
                pend_next      = issue_reg;
                pend_addr_next = rd_addr_reg;
                if (issue_reg)
                begin
                    if (rd_addr_reg == at_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg - AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                else if (!issue_reg)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = at_reg;
                    ram_wdata              = value_reg;
                    count_next             = count_reg + CW'(1);
                    rsp_next.status        = ST_OK;
                    rsp_next.length        = LEN_W'(count_reg + CW'(1));
                    rsp_next.removed_value = '0;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            S_DEL:
            begin
                // Read upward from the target; the first word is the one removed.
                ram_re         = issue_reg;
                pend_next      = issue_reg;
                pend_addr_next = rd_addr_reg;
                if (issue_reg)
                begin
                    if (rd_addr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (pend_addr_reg == at_reg)
                    begin
                        removed_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_addr_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                else if (!issue_reg)
                begin
                    count_next             = count_reg - CW'(1);
                    rsp_next.status        = ST_OK;
                    rsp_next.length        = LEN_W'(count_reg - CW'(1));
                    rsp_next.removed_value = removed_reg;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        at_reg        <= at_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        value_reg     <= value_next;
        removed_reg   <= removed_next;
        rsp_reg       <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
